// ===== rtl/nfa_regex_leftmost_longest_search_assert.svh =====
// ----------------------------------------------------------------------------
// NFA regex search assertion macros
// Clocked property wrappers shared by the search block.
// ----------------------------------------------------------------------------
`ifndef NFA_REGEX_LEFTMOST_LONGEST_SEARCH_ASSERT_SVH
`define NFA_REGEX_LEFTMOST_LONGEST_SEARCH_ASSERT_SVH

// Property sampled on clk, masked while rst_n is low
`define NRL_ASSERT_CLK(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Antecedent in one cycle, consequent in the next
`define NRL_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// ===== rtl/nrl_pkg.sv =====
// ----------------------------------------------------------------------------
// NFA regex search package
// Shared constants, codes, cell control type and case folding.
// ----------------------------------------------------------------------------
package nrl_pkg;

  localparam int unsigned MAX_ATOMS_DEF  = 256;
  localparam int unsigned TEXT_LIMIT_DEF = 65536;
  localparam logic [7:0]  CASE_GAP       = 8'd32;

  typedef enum logic [2:0] {
    OP_LOAD_SET   = 3'd0,
    OP_LOAD_FLAGS = 3'd1,
    OP_BEGIN      = 3'd2,
    OP_DATA       = 3'd3,
    OP_END        = 3'd4
  } opcode_t;

  localparam logic [2:0] REG_IGNORE_CASE  = 3'd0;
  localparam logic [2:0] REG_ANCHOR_START = 3'd1;
  localparam logic [2:0] REG_ANCHOR_END   = 3'd2;
  localparam logic [2:0] REG_ATOM_COUNT   = 3'd3;
  localparam logic [2:0] REG_START_OFFSET = 3'd4;

  localparam logic [1:0] KIND_ONE  = 2'd0;
  localparam logic [1:0] KIND_OPT  = 2'd1;
  localparam logic [1:0] KIND_STAR = 2'd2;
  localparam logic [1:0] KIND_PLUS = 2'd3;

  typedef enum logic [3:0] {
    CMD_IDLE,
    CMD_LOAD_SET,
    CMD_LOAD_FLAGS,
    CMD_CLEAR,
    CMD_PREP,
    CMD_SEED,
    CMD_ADV_INIT,
    CMD_ADV,
    CMD_COMMIT
  } cell_cmd_t;

  typedef struct packed {
    cell_cmd_t   cmd;
    logic        ignore_case;
    logic [7:0]  atom_index;
    logic [1:0]  word_select;
    logic [63:0] set_word;
    logic        negate;
    logic [1:0]  repeat_kind;
    logic [7:0]  data_byte;
  } cell_ctrl_t;

  function automatic logic [7:0] other_case(input logic [7:0] v);
    logic [7:0] r;
    r = v;
    if (v >= 8'h41 && v <= 8'h5a) r = v + CASE_GAP;
    else if (v >= 8'h61 && v <= 8'h7a) r = v - CASE_GAP;
    return r;
  endfunction

endpackage

// ===== rtl/nrl_cell.sv =====
// ----------------------------------------------------------------------------
// NFA regex search cell
// One atom: byte set, flags, live thread start and the closure wave.
// ----------------------------------------------------------------------------
module nrl_cell #(
  parameter int IDX   = 0,
  parameter int POS_W = 17,
  parameter int CNT_W = 9
) (
  input  logic                clk,
  input  logic                rst_n,
  input  nrl_pkg::cell_ctrl_t ctrl,
  input  logic [CNT_W-1:0]    n,
  input  logic                tok_in_v,
  input  logic [POS_W-1:0]    tok_in_s,
  output logic                tok_out_v,
  output logic [POS_W-1:0]    tok_out_s,
  output logic                thr_v,
  output logic [POS_W-1:0]    thr_s
);

  logic [255:0]     set_r;
  logic             neg_r;
  logic [1:0]       kind_r;
  logic             thr_v_r, thr_v_nxt;
  logic [POS_W-1:0] thr_s_r, thr_s_nxt;
  logic             scr_v_r, scr_v_nxt;
  logic [POS_W-1:0] scr_s_r, scr_s_nxt;
  logic             out_v_r, out_v_nxt;
  logic [POS_W-1:0] out_s_r, out_s_nxt;
  logic             below_n, upto_n, load_sel, skip, member, emit;

  function automatic logic take(input logic ov, input logic [POS_W-1:0] os,
                                input logic nv, input logic [POS_W-1:0] ns);
    return nv && (!ov || ns < os);
  endfunction

  assign below_n  = 32'(n) > 32'(IDX);
  assign upto_n   = 32'(n) >= 32'(IDX);
  assign load_sel = 32'(ctrl.atom_index) == 32'(IDX);
  assign skip     = below_n && (kind_r == nrl_pkg::KIND_OPT || kind_r == nrl_pkg::KIND_STAR);
  assign member   = set_r[ctrl.data_byte] ||
                    (ctrl.ignore_case && set_r[nrl_pkg::other_case(ctrl.data_byte)]);
  assign emit     = below_n && thr_v_r && (member ^ neg_r);

  always_comb begin
    thr_v_nxt = thr_v_r;
    thr_s_nxt = thr_s_r;
    scr_v_nxt = scr_v_r;
    scr_s_nxt = scr_s_r;
    out_v_nxt = out_v_r;
    out_s_nxt = out_s_r;
    case (ctrl.cmd)
      nrl_pkg::CMD_CLEAR: begin
        thr_v_nxt = 1'b0;
      end
      nrl_pkg::CMD_PREP: begin
        scr_v_nxt = 1'b0;
        out_v_nxt = 1'b0;
      end
      nrl_pkg::CMD_SEED: begin
        if (upto_n && take(thr_v_r, thr_s_r, tok_in_v, tok_in_s)) begin
          thr_v_nxt = 1'b1;
          thr_s_nxt = tok_in_s;
        end
        if (skip && take(out_v_r, out_s_r, tok_in_v, tok_in_s)) begin
          out_v_nxt = 1'b1;
          out_s_nxt = tok_in_s;
        end
      end
      nrl_pkg::CMD_ADV_INIT: begin
        // hand the thread on; star and plus also keep it here
        out_v_nxt = emit;
        out_s_nxt = thr_s_r;
        scr_v_nxt = emit && (kind_r == nrl_pkg::KIND_STAR || kind_r == nrl_pkg::KIND_PLUS);
        scr_s_nxt = thr_s_r;
      end
      nrl_pkg::CMD_ADV: begin
        if (upto_n && take(scr_v_r, scr_s_r, tok_in_v, tok_in_s)) begin
          scr_v_nxt = 1'b1;
          scr_s_nxt = tok_in_s;
        end
        if (skip && take(out_v_r, out_s_r, tok_in_v, tok_in_s)) begin
          out_v_nxt = 1'b1;
          out_s_nxt = tok_in_s;
        end
      end
      nrl_pkg::CMD_COMMIT: begin
        thr_v_nxt = scr_v_r;
        thr_s_nxt = scr_s_r;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thr_v_r <= 1'b0;
      scr_v_r <= 1'b0;
      out_v_r <= 1'b0;
    end else begin
      thr_v_r <= thr_v_nxt;
      scr_v_r <= scr_v_nxt;
      out_v_r <= out_v_nxt;
    end
    thr_s_r <= thr_s_nxt;
    scr_s_r <= scr_s_nxt;
    out_s_r <= out_s_nxt;
  end

  always_ff @(posedge clk) begin
    if (ctrl.cmd == nrl_pkg::CMD_LOAD_SET && load_sel) begin
      set_r[{ctrl.word_select, 6'd0} +: 64] <= ctrl.set_word;
    end
    if (ctrl.cmd == nrl_pkg::CMD_LOAD_FLAGS && load_sel) begin
      neg_r  <= ctrl.negate;
      kind_r <= ctrl.repeat_kind;
    end
  end

  assign tok_out_v = out_v_r;
  assign tok_out_s = out_s_r;
  assign thr_v     = thr_v_r;
  assign thr_s     = thr_s_r;

endmodule

// ===== rtl/nfa_regex_leftmost_longest_search.sv =====
// ----------------------------------------------------------------------------
// NFA regex leftmost-longest search
// Load and begin complete on acceptance; a data byte runs a seed sweep, a check,
// an advance sweep and a commit; end of input runs a seed sweep and a check and
// then reports (on overflow it reports at once). The closure wave crosses the
// cell row one cell a cycle. One transaction is in work at a time. Synchronous
// reset clears the FSM, thread valid bits, search state and config registers.
// ----------------------------------------------------------------------------
`include "nfa_regex_leftmost_longest_search_assert.svh"

module nfa_regex_leftmost_longest_search #(
  parameter int MAX_ATOMS  = nrl_pkg::MAX_ATOMS_DEF,
  parameter int TEXT_LIMIT = nrl_pkg::TEXT_LIMIT_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [2:0]  in_opcode,
  input  logic [7:0]  in_atom_index,
  input  logic [1:0]  in_word_select,
  input  logic [63:0] in_set_word,
  input  logic        in_negate,
  input  logic [1:0]  in_repeat_kind,
  input  logic [7:0]  in_data_byte,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        out_matched,
  output logic [16:0] out_match_offset,
  output logic [16:0] out_match_length,
  output logic        out_error_code,
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [4:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);

  localparam int CNT_W  = $clog2(MAX_ATOMS + 1);
  localparam int POS_W0 = $clog2(TEXT_LIMIT + 1);
  localparam int POS_W  = (POS_W0 > 17) ? POS_W0 : 17;
  localparam int NCELLS = MAX_ATOMS + 1;
  localparam logic [POS_W-1:0] POS_LIMIT = POS_W'(TEXT_LIMIT);

  typedef enum logic [2:0] {
    ST_IDLE, ST_SEED, ST_CHECK, ST_ADV, ST_COMMIT, ST_REPORT
  } state_t;

  // configuration
  logic        ic_r, as_r, ae_r;
  logic [8:0]  atom_count_r;
  logic [16:0] start_offset_r;
  logic        cfg_wr;

  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ic_r           <= 1'b0;
      as_r           <= 1'b0;
      ae_r           <= 1'b0;
      atom_count_r   <= '0;
      start_offset_r <= '0;
    end else if (cfg_wr) begin
      case (cfg_paddr[4:2])
        nrl_pkg::REG_IGNORE_CASE:  ic_r           <= cfg_pwdata[0];
        nrl_pkg::REG_ANCHOR_START: as_r           <= cfg_pwdata[0];
        nrl_pkg::REG_ANCHOR_END:   ae_r           <= cfg_pwdata[0];
        nrl_pkg::REG_ATOM_COUNT:   atom_count_r   <= cfg_pwdata[8:0];
        nrl_pkg::REG_START_OFFSET: start_offset_r <= cfg_pwdata[16:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    case (cfg_paddr[4:2])
      nrl_pkg::REG_IGNORE_CASE:  cfg_prdata = {31'd0, ic_r};
      nrl_pkg::REG_ANCHOR_START: cfg_prdata = {31'd0, as_r};
      nrl_pkg::REG_ANCHOR_END:   cfg_prdata = {31'd0, ae_r};
      nrl_pkg::REG_ATOM_COUNT:   cfg_prdata = {23'd0, atom_count_r};
      nrl_pkg::REG_START_OFFSET: cfg_prdata = {15'd0, start_offset_r};
      default:                   cfg_prdata = '0;
    endcase
  end

  logic [CNT_W-1:0] n_eff;
  assign n_eff = (32'(atom_count_r) > 32'(MAX_ATOMS)) ? CNT_W'(MAX_ATOMS)
                                                       : CNT_W'(atom_count_r);

  // sequencer state
  state_t           state_r, state_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic [POS_W-1:0] pos_r, pos_nxt;
  logic [POS_W-1:0] bs_r, bs_nxt;
  logic [POS_W-1:0] be_r, be_nxt;
  logic             found_r, found_nxt;
  logic             ovf_r, ovf_nxt;
  logic [7:0]       byte_r, byte_nxt;
  logic             seed_ok_r, seed_ok_nxt;
  logic             is_end_r, is_end_nxt;
  logic             out_valid_r, out_valid_nxt;
  logic             out_matched_r, out_matched_nxt;
  logic [16:0]      out_off_r, out_off_nxt;
  logic [16:0]      out_len_r, out_len_nxt;
  logic             out_err_r, out_err_nxt;
  logic             in_acc;
  logic [POS_W-1:0] len_full;

  nrl_pkg::cell_ctrl_t ctrl;

  logic             tok_v [NCELLS];
  logic [POS_W-1:0] tok_s [NCELLS];
  logic             thr_v [NCELLS];
  logic [POS_W-1:0] thr_s [NCELLS];
  logic             acc_v;
  logic [POS_W-1:0] acc_s;

  assign in_stall = (state_r != ST_IDLE);
  assign in_acc   = in_valid && !in_stall;
  assign acc_v    = thr_v[n_eff];
  assign acc_s    = thr_s[n_eff];
  assign len_full = be_r - bs_r;

  always_comb begin
    state_nxt       = state_r;
    cnt_nxt         = cnt_r;
    pos_nxt         = pos_r;
    bs_nxt          = bs_r;
    be_nxt          = be_r;
    found_nxt       = found_r;
    ovf_nxt         = ovf_r;
    byte_nxt        = byte_r;
    seed_ok_nxt     = seed_ok_r;
    is_end_nxt      = is_end_r;
    out_valid_nxt   = out_valid_r && out_stall;
    out_matched_nxt = out_matched_r;
    out_off_nxt     = out_off_r;
    out_len_nxt     = out_len_r;
    out_err_nxt     = out_err_r;

    ctrl.cmd         = nrl_pkg::CMD_IDLE;
    ctrl.ignore_case = ic_r;
    ctrl.atom_index  = in_atom_index;
    ctrl.word_select = in_word_select;
    ctrl.set_word    = in_set_word;
    ctrl.negate      = in_negate;
    ctrl.repeat_kind = in_repeat_kind;
    ctrl.data_byte   = byte_r;

    case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          case (in_opcode)
            nrl_pkg::OP_LOAD_SET:   ctrl.cmd = nrl_pkg::CMD_LOAD_SET;
            nrl_pkg::OP_LOAD_FLAGS: ctrl.cmd = nrl_pkg::CMD_LOAD_FLAGS;
            nrl_pkg::OP_BEGIN: begin
              ctrl.cmd  = nrl_pkg::CMD_CLEAR;
              pos_nxt   = POS_W'(start_offset_r);
              bs_nxt    = '0;
              be_nxt    = '0;
              found_nxt = 1'b0;
              ovf_nxt   = 1'b0;
            end
            nrl_pkg::OP_DATA: begin
              if (pos_r >= POS_LIMIT) begin
                ovf_nxt = 1'b1;
              end else begin
                ctrl.cmd    = nrl_pkg::CMD_PREP;
                byte_nxt    = in_data_byte;
                seed_ok_nxt = !as_r || (pos_r == '0 && start_offset_r == '0);
                is_end_nxt  = 1'b0;
                cnt_nxt     = '0;
                state_nxt   = ST_SEED;
              end
            end
            nrl_pkg::OP_END: begin
              ovf_nxt = ovf_r || (pos_r > POS_LIMIT);
              if (ovf_nxt) begin
                state_nxt = ST_REPORT;
              end else begin
                ctrl.cmd    = nrl_pkg::CMD_PREP;
                seed_ok_nxt = !as_r || (pos_r == '0 && start_offset_r == '0);
                is_end_nxt  = 1'b1;
                cnt_nxt     = '0;
                state_nxt   = ST_SEED;
              end
            end
            default: begin
            end
          endcase
        end
      end
      ST_SEED: begin
        ctrl.cmd = nrl_pkg::CMD_SEED;
        cnt_nxt  = cnt_r + 1'b1;
        if (cnt_r == n_eff) state_nxt = ST_CHECK;
      end
      ST_CHECK: begin
        if (acc_v && (!ae_r || is_end_r) &&
            (!found_r || acc_s < bs_r || (acc_s == bs_r && pos_r > be_r))) begin
          found_nxt = 1'b1;
          bs_nxt    = acc_s;
          be_nxt    = pos_r;
        end
        if (is_end_r) begin
          state_nxt = ST_REPORT;
        end else begin
          ctrl.cmd  = nrl_pkg::CMD_ADV_INIT;
          cnt_nxt   = '0;
          state_nxt = ST_ADV;
        end
      end
      ST_ADV: begin
        ctrl.cmd = nrl_pkg::CMD_ADV;
        cnt_nxt  = cnt_r + 1'b1;
        if (cnt_r == n_eff) state_nxt = ST_COMMIT;
      end
      ST_COMMIT: begin
        ctrl.cmd  = nrl_pkg::CMD_COMMIT;
        pos_nxt   = pos_r + 1'b1;
        state_nxt = ST_IDLE;
      end
      ST_REPORT: begin
        // hold until the output register is free
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt = 1'b1;
          if (ovf_r) begin
            out_matched_nxt = 1'b0;
            out_off_nxt     = '0;
            out_len_nxt     = '0;
            out_err_nxt     = 1'b1;
          end else if (found_r) begin
            out_matched_nxt = 1'b1;
            out_off_nxt     = bs_r[16:0];
            out_len_nxt     = len_full[16:0];
            out_err_nxt     = 1'b0;
          end else begin
            out_matched_nxt = 1'b0;
            out_off_nxt     = '0;
            out_len_nxt     = '0;
            out_err_nxt     = 1'b0;
          end
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      cnt_r       <= '0;
      pos_r       <= '0;
      bs_r        <= '0;
      be_r        <= '0;
      found_r     <= 1'b0;
      ovf_r       <= 1'b0;
      seed_ok_r   <= 1'b0;
      is_end_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      pos_r       <= pos_nxt;
      bs_r        <= bs_nxt;
      be_r        <= be_nxt;
      found_r     <= found_nxt;
      ovf_r       <= ovf_nxt;
      seed_ok_r   <= seed_ok_nxt;
      is_end_r    <= is_end_nxt;
      out_valid_r <= out_valid_nxt;
    end
    byte_r        <= byte_nxt;
    out_matched_r <= out_matched_nxt;
    out_off_r     <= out_off_nxt;
    out_len_r     <= out_len_nxt;
    out_err_r     <= out_err_nxt;
  end

  // cell row; cell n_eff (the effective atom count) serves as the accept slot
  for (genvar j = 0; j < NCELLS; j++) begin : g_cell
    logic             in_v;
    logic [POS_W-1:0] in_s;
    if (j == 0) begin : g_head
      assign in_v = (state_r == ST_SEED) && seed_ok_r;
      assign in_s = pos_r;
    end else begin : g_link
      assign in_v = tok_v[j-1];
      assign in_s = tok_s[j-1];
    end
    nrl_cell #(
      .IDX   (j),
      .POS_W (POS_W),
      .CNT_W (CNT_W)
    ) u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .ctrl      (ctrl),
      .n         (n_eff),
      .tok_in_v  (in_v),
      .tok_in_s  (in_s),
      .tok_out_v (tok_v[j]),
      .tok_out_s (tok_s[j]),
      .thr_v     (thr_v[j]),
      .thr_s     (thr_s[j])
    );
  end

  assign out_valid        = out_valid_r;
  assign out_matched      = out_matched_r;
  assign out_match_offset = out_off_r;
  assign out_match_length = out_len_r;
  assign out_error_code   = out_err_r;

  `NRL_ASSERT_CLK(a_cnt_range, ((state_r == ST_SEED || state_r == ST_ADV) |-> (cnt_r <= n_eff)), "sweep counter past chain end")
  `NRL_ASSERT_CLK(a_best_order, (found_r |-> (be_r >= bs_r)), "best match ends before it starts")
  `NRL_ASSERT_NEXT(a_report, (state_r == ST_REPORT && (!out_valid_r || !out_stall)), out_valid_r, "result not presented")
  `NRL_ASSERT_CLK(a_pos_limit, ((state_r == ST_COMMIT) |-> (pos_r < POS_LIMIT)), "position advanced past limit")

endmodule
